### sv/btlpm_pkg.sv
// Shared types and constants for the binary trie longest-prefix-match table.
// No dependencies; imported by btlpm_ctl, btlpm_dp and binary_trie_lpm_table.
package btlpm_pkg;

   localparam int ADDR_BITS = 32;
   localparam int ROUTE_CAP_DEF = 256;
   localparam int NODE_CAP_DEF = 8192;
   localparam int LEN_W = 6;
   localparam int DATA_W = 64;
   localparam int LIMIT_W = 9;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_SET = 3'd2;
   localparam logic [2:0] OP_GET = 3'd3;
   localparam logic [2:0] OP_LOOKUP = 3'd4;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EXISTS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   localparam logic CSR_ROUTE_LIMIT = 1'b0;
   localparam logic CSR_HIT_ENABLE = 1'b1;

   typedef struct packed {
      logic [2:0]        req_type;
      logic [31:0]       prefix_bits;
      logic [LEN_W-1:0]  prefix_len;
      logic [DATA_W-1:0] data_in;
      logic              clear_hits;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [DATA_W-1:0] data_out;
      logic [DATA_W-1:0] hits_out;
      logic [LEN_W-1:0]  match_len;
   } rsp_payload_type;

   typedef enum logic [5:0] {
      S_IDLE, S_DISPATCH, S_W_RD, S_W_CHK, S_F_RD, S_F_CHK, S_POST,
      S_I_ROOT, S_I_NEW, S_I_LINK, S_I_ROUTE,
      S_D_CLR, S_D_RRD, S_D_RWR, S_D_ORD, S_D_OWR, S_D_DEC,
      S_C_RD, S_C_CHK, S_P_RD, S_P_WR, S_L_CHK,
      S_M_RD, S_M_WR, S_M_LRD, S_M_LWR, S_M_RRD, S_M_RWR, S_M_PRD, S_M_PWR,
      S_L_END, S_K_RD, S_K_CHK, S_K_END, S_RT_RD, S_RT_FIN, S_DONE
   } ctl_state_type;

   typedef struct packed {
      logic [2:0] op;
      logic       full_limit;
      logic       root_zero;
      logic       len_zero;
      logic       child_zero;
      logic       last_level;
      logic       found_zero;
      logic       rt_zero;
      logic       exists;
      logic       nodes_short;
      logic       rt_is_last;
      logic       node_zero;
      logic       prunable;
      logic       nd_parent_zero;
      logic       node_is_last;
      logic       m_left_zero;
      logic       m_right_zero;
      logic       m_parent_zero;
      logic       i_at_end;
   } dp_status_type;

endpackage

### sv/btlpm_ctl.sv
// Controller state machine for the trie table.
// Depends on btlpm_pkg; drives btlpm_dp through its command input.
module btlpm_ctl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  btlpm_pkg::dp_status_type stat,
   output btlpm_pkg::ctl_state_type cmd,
   output logic                     busy,
   output logic                     rsp_valid
);
   import btlpm_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (start) state_in = S_DISPATCH;
         S_DISPATCH: begin
            if (stat.op == OP_LOOKUP) state_in = S_K_RD;
            else if (stat.op > OP_LOOKUP) state_in = S_DONE;
            else if (stat.op == OP_INSERT && stat.full_limit) state_in = S_DONE;
            else if (stat.root_zero) state_in = S_POST;
            else if (stat.len_zero) state_in = S_F_RD;
            else state_in = S_W_RD;
         end
         S_W_RD: state_in = S_W_CHK;
         S_W_CHK: begin
            if (stat.child_zero) state_in = S_POST;
            else if (stat.last_level) state_in = S_F_RD;
            else state_in = S_W_RD;
         end
         S_F_RD: state_in = S_F_CHK;
         S_F_CHK: state_in = S_POST;
         S_POST: begin
            case (stat.op)
               OP_INSERT: begin
                  if (stat.exists || stat.nodes_short) state_in = S_DONE;
                  else if (!stat.found_zero) state_in = S_I_ROUTE;
                  else if (stat.root_zero) state_in = S_I_ROOT;
                  else state_in = S_I_NEW;
               end
               OP_DELETE: state_in = stat.rt_zero ? S_DONE : S_D_CLR;
               OP_GET: state_in = stat.rt_zero ? S_DONE : S_RT_RD;
               default: state_in = S_DONE;
            endcase
         end
         S_I_ROOT: state_in = stat.len_zero ? S_I_ROUTE : S_I_NEW;
         S_I_NEW: state_in = S_I_LINK;
         S_I_LINK: state_in = stat.last_level ? S_I_ROUTE : S_I_NEW;
         S_I_ROUTE: state_in = S_DONE;
         S_D_CLR: state_in = stat.rt_is_last ? S_D_DEC : S_D_RRD;
         S_D_RRD: state_in = S_D_RWR;
         S_D_RWR: state_in = S_D_ORD;
         S_D_ORD: state_in = S_D_OWR;
         S_D_OWR: state_in = S_D_DEC;
         S_D_DEC: state_in = S_C_RD;
         S_C_RD: state_in = stat.node_zero ? S_DONE : S_C_CHK;
         S_C_CHK: begin
            if (!stat.prunable) state_in = S_DONE;
            else if (stat.nd_parent_zero) state_in = S_L_CHK;
            else state_in = S_P_RD;
         end
         S_P_RD: state_in = S_P_WR;
         S_P_WR: state_in = S_L_CHK;
         S_L_CHK: state_in = stat.node_is_last ? S_L_END : S_M_RD;
         S_M_RD: state_in = S_M_WR;
         S_M_WR: state_in = S_M_LRD;
         S_M_LRD: state_in = stat.m_left_zero ? S_M_RRD : S_M_LWR;
         S_M_LWR: state_in = S_M_RRD;
         S_M_RRD: state_in = stat.m_right_zero ? S_M_PRD : S_M_RWR;
         S_M_RWR: state_in = S_M_PRD;
         S_M_PRD: state_in = stat.m_parent_zero ? S_L_END : S_M_PWR;
         S_M_PWR: state_in = S_L_END;
         S_L_END: state_in = S_C_RD;
         S_K_RD: state_in = stat.found_zero ? S_K_END : S_K_CHK;
         S_K_CHK: state_in = stat.i_at_end ? S_K_END : S_K_RD;
         S_K_END: state_in = stat.rt_zero ? S_DONE : S_RT_RD;
         S_RT_RD: state_in = S_RT_FIN;
         S_RT_FIN: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = state_ff;
      busy = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_DONE);
   end

endmodule

### sv/btlpm_dp.sv
// Datapath for the trie table: node and route stores, walk registers, counters.
// Depends on btlpm_pkg; sequenced by btlpm_ctl through cmd.
module btlpm_dp #(
   parameter int ROUTE_CAP = btlpm_pkg::ROUTE_CAP_DEF,
   parameter int NODE_CAP = btlpm_pkg::NODE_CAP_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  btlpm_pkg::ctl_state_type          cmd,
   input  btlpm_pkg::req_payload_type        req_data,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [btlpm_pkg::LIMIT_W-1:0]     csr_wdata,
   output btlpm_pkg::dp_status_type          stat,
   output btlpm_pkg::rsp_payload_type        rsp_data
);
   import btlpm_pkg::*;

   localparam int NW = $clog2(NODE_CAP + 1);
   localparam int RW = $clog2(ROUTE_CAP + 1);

   typedef struct packed {
      logic [NW-1:0] left;
      logic [NW-1:0] right;
      logic [NW-1:0] parent;
      logic [RW-1:0] route;
   } slot_type;

   slot_type          node_mem [0:NODE_CAP];
   logic [DATA_W-1:0] data_mem [0:ROUTE_CAP];
   logic [DATA_W-1:0] hits_mem [0:ROUTE_CAP];
   logic [NW-1:0]     owner_mem [0:ROUTE_CAP];

   slot_type          node_rd_ff;
   logic [DATA_W-1:0] data_rd_ff, hits_rd_ff;
   logic [NW-1:0]     owner_rd_ff;

   logic              nwe, dwe, hwe, owe;
   logic [NW-1:0]     nwa, nra, owd;
   slot_type          nwd;
   logic [RW-1:0]     dwa, hwa, owa, rra;
   logic [DATA_W-1:0] dwd, hwd;

   logic [2:0]        op_ff, op_in;
   logic [31:0]       key_ff, key_in;
   logic [LEN_W-1:0]  len_ff, len_in, i_ff, i_in, depth_ff, depth_in, blen_ff, blen_in;
   logic [DATA_W-1:0] data_ff, data_in_w;
   logic              clr_ff, clr_in;
   logic [NW-1:0]     p_ff, p_in, last_ff, last_in, node_ff, node_in;
   logic [NW-1:0]     parent_ff, parent_in, own_ff, own_in, newn_ff, newn_in;
   slot_type          lastslot_ff, lastslot_in, mslot_ff, mslot_in;
   logic [RW-1:0]     rt_ff, rt_in;
   logic [1:0]        status_ff, status_in;
   logic [DATA_W-1:0] dout_ff, dout_in, hout_ff, hout_in;
   logic [LEN_W-1:0]  mlen_ff, mlen_in;
   logic [NW-1:0]     root_ff, root_in, nodes_used_ff, nodes_used_in;
   logic [RW-1:0]     routes_used_ff, routes_used_in;
   logic [LIMIT_W-1:0] lim_ff, lim_in;
   logic              hen_ff, hen_in;

   logic              kbit;
   logic [NW-1:0]     child;
   logic [31:0]       need;

   always_ff @(posedge clock) begin
      if (nwe) node_mem[nwa] <= nwd;
      node_rd_ff <= node_mem[nra];
   end

   always_ff @(posedge clock) begin
      if (dwe) data_mem[dwa] <= dwd;
      data_rd_ff <= data_mem[rra];
   end

   always_ff @(posedge clock) begin
      if (hwe) hits_mem[hwa] <= hwd;
      hits_rd_ff <= hits_mem[rra];
   end

   always_ff @(posedge clock) begin
      if (owe) owner_mem[owa] <= owd;
      owner_rd_ff <= owner_mem[rra];
   end

   assign kbit = key_ff[5'(ADDR_BITS - 1) - i_ff[4:0]];
   assign child = kbit ? node_rd_ff.right : node_rd_ff.left;
   assign need = 32'(root_ff == '0) + 32'(len_ff) - 32'(depth_ff);

   always_comb begin
      stat.op = op_ff;
      stat.full_limit = (32'(routes_used_ff) >= 32'(lim_ff))
                        || (32'(routes_used_ff) >= ROUTE_CAP);
      stat.root_zero = (root_ff == '0);
      stat.len_zero = (len_ff == '0);
      stat.child_zero = (child == '0);
      stat.last_level = ((i_ff + LEN_W'(1)) == len_ff);
      stat.found_zero = (p_ff == '0);
      stat.rt_zero = (rt_ff == '0);
      stat.exists = (p_ff != '0) && (rt_ff != '0);
      stat.nodes_short = (p_ff == '0)
                         && ((32'(need) + 32'(nodes_used_ff)) > 32'(NODE_CAP));
      stat.rt_is_last = (rt_ff == routes_used_ff);
      stat.node_zero = (node_ff == '0);
      stat.prunable = (node_rd_ff.route == '0) && (node_rd_ff.left == '0)
                      && (node_rd_ff.right == '0);
      stat.nd_parent_zero = (node_rd_ff.parent == '0);
      stat.node_is_last = (node_ff == nodes_used_ff);
      stat.m_left_zero = (mslot_ff.left == '0);
      stat.m_right_zero = (mslot_ff.right == '0);
      stat.m_parent_zero = (mslot_ff.parent == '0);
      stat.i_at_end = (i_ff == LEN_W'(ADDR_BITS));
   end

   always_comb begin
      op_in = op_ff; key_in = key_ff; len_in = len_ff; data_in_w = data_ff;
      clr_in = clr_ff; p_in = p_ff; i_in = i_ff; depth_in = depth_ff;
      blen_in = blen_ff; last_in = last_ff; node_in = node_ff;
      parent_in = parent_ff; own_in = own_ff; newn_in = newn_ff;
      lastslot_in = lastslot_ff; mslot_in = mslot_ff; rt_in = rt_ff;
      status_in = status_ff; dout_in = dout_ff; hout_in = hout_ff; mlen_in = mlen_ff;
      root_in = root_ff; nodes_used_in = nodes_used_ff;
      routes_used_in = routes_used_ff; lim_in = lim_ff; hen_in = hen_ff;
      nwe = 1'b0; nwa = '0; nwd = '0; nra = p_ff; rra = rt_ff;
      dwe = 1'b0; dwa = rt_ff; dwd = data_ff;
      hwe = 1'b0; hwa = rt_ff; hwd = '0;
      owe = 1'b0; owa = rt_ff; owd = last_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_ROUTE_LIMIT: lim_in = csr_wdata;
            CSR_HIT_ENABLE: hen_in = csr_wdata[0];
            default: lim_in = lim_ff;
         endcase
      end

      unique case (cmd)
         S_IDLE: begin
            op_in = req_data.req_type;
            key_in = req_data.prefix_bits;
            len_in = (req_data.prefix_len > LEN_W'(ADDR_BITS)) ? LEN_W'(ADDR_BITS)
                                                                : req_data.prefix_len;
            data_in_w = req_data.data_in;
            clr_in = req_data.clear_hits;
            p_in = root_ff;
            i_in = '0;
            depth_in = '0;
            blen_in = '0;
            last_in = '0;
            lastslot_in = '0;
            rt_in = '0;
            status_in = ST_NOT_FOUND;
            dout_in = '0;
            hout_in = '0;
            mlen_in = '0;
         end
         S_DISPATCH: begin
            if (op_ff == OP_INSERT && stat.full_limit) status_in = ST_FULL;
         end
         S_W_RD: nra = p_ff;
         S_W_CHK: begin
            last_in = p_ff;
            depth_in = i_ff;
            lastslot_in = node_rd_ff;
            p_in = child;
            i_in = i_ff + LEN_W'(1);
         end
         S_F_RD: nra = p_ff;
         S_F_CHK: begin
            last_in = p_ff;
            lastslot_in = node_rd_ff;
            rt_in = node_rd_ff.route;
         end
         S_POST: begin
            case (op_ff)
               OP_INSERT: begin
                  if (stat.exists) begin
                     status_in = ST_EXISTS;
                  end else if (stat.nodes_short) begin
                     status_in = ST_FULL;
                  end else begin
                     routes_used_in = routes_used_ff + RW'(1);
                     rt_in = routes_used_ff + RW'(1);
                     dwe = 1'b1;
                     dwa = routes_used_ff + RW'(1);
                     hwe = 1'b1;
                     hwa = routes_used_ff + RW'(1);
                     i_in = depth_ff;
                  end
               end
               OP_DELETE: if (!stat.rt_zero) status_in = ST_OK;
               OP_SET: begin
                  if (!stat.rt_zero) begin
                     status_in = ST_OK;
                     dwe = 1'b1;
                  end
               end
               default: status_in = status_ff;
            endcase
         end
         S_I_ROOT: begin
            nwe = 1'b1;
            nwa = nodes_used_ff + NW'(1);
            nodes_used_in = nodes_used_ff + NW'(1);
            root_in = nodes_used_ff + NW'(1);
            last_in = nodes_used_ff + NW'(1);
            lastslot_in = '0;
         end
         S_I_NEW: begin
            nwe = 1'b1;
            nwa = nodes_used_ff + NW'(1);
            nwd.parent = last_ff;
            nodes_used_in = nodes_used_ff + NW'(1);
            newn_in = nodes_used_ff + NW'(1);
         end
         S_I_LINK: begin
            nwe = 1'b1;
            nwa = last_ff;
            nwd = lastslot_ff;
            if (kbit) nwd.right = newn_ff;
            else nwd.left = newn_ff;
            last_in = newn_ff;
            lastslot_in = '0;
            lastslot_in.parent = last_ff;
            i_in = i_ff + LEN_W'(1);
         end
         S_I_ROUTE: begin
            nwe = 1'b1;
            nwa = last_ff;
            nwd = lastslot_ff;
            nwd.route = rt_ff;
            owe = 1'b1;
            status_in = ST_OK;
         end
         S_D_CLR: begin
            nwe = 1'b1;
            nwa = last_ff;
            nwd = lastslot_ff;
            nwd.route = '0;
         end
         S_D_RRD: rra = routes_used_ff;
         S_D_RWR: begin
            dwe = 1'b1;
            dwd = data_rd_ff;
            hwe = 1'b1;
            hwd = hits_rd_ff;
            owe = 1'b1;
            owd = owner_rd_ff;
            own_in = owner_rd_ff;
         end
         S_D_ORD: nra = own_ff;
         S_D_OWR: begin
            nwe = 1'b1;
            nwa = own_ff;
            nwd = node_rd_ff;
            nwd.route = rt_ff;
         end
         S_D_DEC: begin
            routes_used_in = routes_used_ff - RW'(1);
            node_in = last_ff;
         end
         S_C_RD: nra = node_ff;
         S_C_CHK: begin
            parent_in = node_rd_ff.parent;
            if (stat.prunable && stat.nd_parent_zero) root_in = '0;
         end
         S_P_RD: nra = parent_ff;
         S_P_WR: begin
            nwe = 1'b1;
            nwa = parent_ff;
            nwd = node_rd_ff;
            if (node_rd_ff.left == node_ff) nwd.left = '0;
            else nwd.right = '0;
         end
         S_M_RD: nra = nodes_used_ff;
         S_M_WR: begin
            nwe = 1'b1;
            nwa = node_ff;
            nwd = node_rd_ff;
            mslot_in = node_rd_ff;
            if (node_rd_ff.route != '0) begin
               owe = 1'b1;
               owa = node_rd_ff.route;
               owd = node_ff;
            end
         end
         S_M_LRD: nra = mslot_ff.left;
         S_M_LWR: begin
            nwe = 1'b1;
            nwa = mslot_ff.left;
            nwd = node_rd_ff;
            nwd.parent = node_ff;
         end
         S_M_RRD: nra = mslot_ff.right;
         S_M_RWR: begin
            nwe = 1'b1;
            nwa = mslot_ff.right;
            nwd = node_rd_ff;
            nwd.parent = node_ff;
         end
         S_M_PRD: begin
            nra = mslot_ff.parent;
            if (mslot_ff.parent == '0) root_in = node_ff;
         end
         S_M_PWR: begin
            nwe = 1'b1;
            nwa = mslot_ff.parent;
            nwd = node_rd_ff;
            if (node_rd_ff.left == nodes_used_ff) nwd.left = node_ff;
            else nwd.right = node_ff;
         end
         S_L_END: begin
            nodes_used_in = nodes_used_ff - NW'(1);
            if (node_ff != nodes_used_ff && parent_ff == nodes_used_ff) node_in = node_ff;
            else node_in = parent_ff;
         end
         S_K_RD: nra = p_ff;
         S_K_CHK: begin
            if (node_rd_ff.route != '0) begin
               rt_in = node_rd_ff.route;
               blen_in = i_ff;
            end
            if (!stat.i_at_end) begin
               p_in = child;
               i_in = i_ff + LEN_W'(1);
            end
         end
         S_RT_RD: rra = rt_ff;
         S_RT_FIN: begin
            status_in = ST_OK;
            dout_in = data_rd_ff;
            if (op_ff == OP_GET) begin
               if (hen_ff) hout_in = hits_rd_ff;
               if (hen_ff && clr_ff) hwe = 1'b1;
            end else begin
               mlen_in = blen_ff;
               if (hen_ff) begin
                  hwe = 1'b1;
                  hwd = hits_rd_ff + 64'd1;
               end
            end
         end
         default: nwe = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in; key_ff <= key_in; len_ff <= len_in; data_ff <= data_in_w;
      clr_ff <= clr_in; p_ff <= p_in; i_ff <= i_in; depth_ff <= depth_in;
      blen_ff <= blen_in; last_ff <= last_in; node_ff <= node_in;
      parent_ff <= parent_in; own_ff <= own_in; newn_ff <= newn_in;
      lastslot_ff <= lastslot_in; mslot_ff <= mslot_in; rt_ff <= rt_in;
      status_ff <= status_in; dout_ff <= dout_in; hout_ff <= hout_in;
      mlen_ff <= mlen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
         nodes_used_ff <= '0;
         routes_used_ff <= '0;
         lim_ff <= LIMIT_W'(256);
         hen_ff <= 1'b0;
      end else begin
         root_ff <= root_in;
         nodes_used_ff <= nodes_used_in;
         routes_used_ff <= routes_used_in;
         lim_ff <= lim_in;
         hen_ff <= hen_in;
      end
   end

   always_comb begin
      rsp_data.status = status_ff;
      rsp_data.data_out = dout_ff;
      rsp_data.hits_out = hout_ff;
      rsp_data.match_len = mlen_ff;
   end

endmodule

### sv/binary_trie_lpm_table.sv
// Top level of the binary trie longest-prefix-match route table.
// Depends on btlpm_pkg, btlpm_ctl and btlpm_dp.
//
//   channel   ports                          handshake
//   request   start, busy, req_data          taken when start & !busy
//   result    rsp_valid, rsp_data            one-cycle strobe, no backpressure
//   config    csr_we, csr_index, csr_wdata   write when csr_we
//
// One request at a time; the node store has one read and one write per cycle.
// Lookup reads and checks one trie level at a time until the key runs out or a
// child is missing. Insert walks, then adds nodes and the route. Delete walks,
// then prunes empty nodes. Busy holds further requests off until the strobe.
// Reset is synchronous; the table is empty after it, no clearing pass.
module binary_trie_lpm_table #(
   parameter int ROUTE_CAP = btlpm_pkg::ROUTE_CAP_DEF,
   parameter int NODE_CAP = btlpm_pkg::NODE_CAP_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  btlpm_pkg::req_payload_type    req_data,
   output logic                          rsp_valid,
   output btlpm_pkg::rsp_payload_type    rsp_data,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [btlpm_pkg::LIMIT_W-1:0] csr_wdata
);
   import btlpm_pkg::*;

   ctl_state_type cmd;
   dp_status_type stat;

   btlpm_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   btlpm_dp #(
      .ROUTE_CAP (ROUTE_CAP),
      .NODE_CAP  (NODE_CAP)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

endmodule

### sim/binary_trie_lpm_table_checker.sv
`timescale 1ns / 1ps
// Checker for the binary trie longest-prefix-match table: watches the request,
// result and register channels, predicts each result and compares. Uses btlpm_pkg.
module binary_trie_lpm_table_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  btlpm_pkg::req_payload_type    req_data,
   input  logic                          rsp_valid,
   input  btlpm_pkg::rsp_payload_type    rsp_data,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [btlpm_pkg::LIMIT_W-1:0] csr_wdata,
   output int                            fail_count,
   output int                            pending
);
   import btlpm_pkg::*;

   localparam int NODES = NODE_CAP_DEF;
   localparam int ROUTES = ROUTE_CAP_DEF;

   int unsigned trie_left [0:NODES];
   int unsigned trie_right [0:NODES];
   int unsigned trie_parent [0:NODES];
   int unsigned slot_route [0:NODES];
   logic [63:0] route_value [0:ROUTES];
   logic [63:0] route_tally [0:ROUTES];
   int unsigned owner_node [0:ROUTES];
   int unsigned trie_root, node_count, route_count;
   logic [LIMIT_W-1:0] limit_reg;
   logic hits_on;

   rsp_payload_type expected_rsp[$];

   function automatic int unsigned key_bit(logic [31:0] key, int unsigned i);
      return 32'(key[31 - i]);
   endfunction

   function automatic int unsigned child(int unsigned n, int unsigned b);
      return b ? trie_right[n] : trie_left[n];
   endfunction

   task automatic trace_path(input logic [31:0] key, input int unsigned len,
                             output int unsigned found, output int unsigned last,
                             output int unsigned depth);
      int unsigned p;
      p = trie_root;
      found = 0; last = 0; depth = 0;
      if (p != 0) begin
         for (int unsigned i = 0; i < len; i++) begin
            last = p;
            depth = i;
            p = child(p, key_bit(key, i));
            if (p == 0) break;
         end
         found = p;
      end
   endtask

   function automatic int unsigned grab_node(int unsigned parent);
      node_count++;
      trie_left[node_count] = 0;
      trie_right[node_count] = 0;
      slot_route[node_count] = 0;
      trie_parent[node_count] = parent;
      return node_count;
   endfunction

   task automatic add_route(input logic [31:0] key, input int unsigned len,
                            input logic [63:0] data, output logic [1:0] status);
      int unsigned found, last, depth, need, r, p, lim;
      lim = (limit_reg > ROUTES) ? ROUTES : limit_reg;
      if (route_count >= lim) begin
         status = ST_FULL;
         return;
      end
      trace_path(key, len, found, last, depth);
      if (found != 0 && slot_route[found] != 0) begin
         status = ST_EXISTS;
         return;
      end
      need = 0;
      if (found == 0) need = (trie_root == 0 ? 1 : 0) + (len - depth);
      if (need > NODES - node_count) begin
         status = ST_FULL;
         return;
      end
      route_count++;
      r = route_count;
      route_value[r] = data;
      route_tally[r] = '0;
      if (found == 0) begin
         if (trie_root == 0) trie_root = grab_node(0);
         p = trie_root;
         if (last == 0) last = trie_root;
         for (int unsigned i = depth; i < len; i++) begin
            p = grab_node(last);
            if (key_bit(key, i)) trie_right[last] = p;
            else trie_left[last] = p;
            last = p;
         end
         found = p;
      end
      slot_route[found] = r;
      owner_node[r] = found;
      status = ST_OK;
   endtask

   task automatic drop_route(input int unsigned node);
      int unsigned r, lr, parent, ln, ml, mr, mp, mrt;
      r = slot_route[node];
      lr = route_count;
      slot_route[node] = 0;
      if (r != lr) begin
         route_value[r] = route_value[lr];
         route_tally[r] = route_tally[lr];
         owner_node[r] = owner_node[lr];
         slot_route[owner_node[r]] = r;
      end
      route_count--;
      while (node != 0 && slot_route[node] == 0 && trie_left[node] == 0 &&
             trie_right[node] == 0) begin
         parent = trie_parent[node];
         if (parent != 0) begin
            if (trie_left[parent] == node) trie_left[parent] = 0;
            else trie_right[parent] = 0;
         end else begin
            trie_root = 0;
         end
         ln = node_count;
         if (node != ln) begin
            ml = trie_left[ln]; mr = trie_right[ln];
            mp = trie_parent[ln]; mrt = slot_route[ln];
            trie_left[node] = ml; trie_right[node] = mr;
            trie_parent[node] = mp; slot_route[node] = mrt;
            if (mrt != 0) owner_node[mrt] = node;
            if (ml != 0) trie_parent[ml] = node;
            if (mr != 0) trie_parent[mr] = node;
            if (mp != 0) begin
               if (trie_left[mp] == ln) trie_left[mp] = node;
               else trie_right[mp] = node;
            end else begin
               trie_root = node;
            end
            if (parent == ln) parent = node;
         end
         node_count--;
         node = parent;
      end
   endtask

   task automatic predict_response(input req_payload_type rq, output rsp_payload_type rs);
      int unsigned len, found, last, depth, r, p, i, best, best_len;
      rs = '0;
      rs.status = ST_NOT_FOUND;
      len = (rq.prefix_len > ADDR_BITS) ? ADDR_BITS : rq.prefix_len;
      case (rq.req_type) inside
         OP_INSERT: add_route(rq.prefix_bits, len, rq.data_in, rs.status);
         OP_DELETE, OP_SET, OP_GET: begin
            trace_path(rq.prefix_bits, len, found, last, depth);
            r = found ? slot_route[found] : 0;
            if (r != 0) begin
               rs.status = ST_OK;
               if (rq.req_type == OP_DELETE) begin
                  drop_route(found);
               end else if (rq.req_type == OP_SET) begin
                  route_value[r] = rq.data_in;
               end else begin
                  rs.data_out = route_value[r];
                  if (hits_on) begin
                     rs.hits_out = route_tally[r];
                     if (rq.clear_hits) route_tally[r] = '0;
                  end
               end
            end
         end
         OP_LOOKUP: begin
            p = trie_root; i = 0; best = 0; best_len = 0;
            while (p != 0) begin
               if (slot_route[p] != 0) begin
                  best = p;
                  best_len = i;
               end
               if (i >= ADDR_BITS) break;
               p = child(p, key_bit(rq.prefix_bits, i));
               i++;
            end
            if (best != 0) begin
               r = slot_route[best];
               rs.status = ST_OK;
               rs.data_out = route_value[r];
               rs.match_len = LEN_W'(best_len);
               if (hits_on) route_tally[r] = route_tally[r] + 64'd1;
            end
         end
         default: ;
      endcase
   endtask

   assign pending = expected_rsp.size();

   always @(posedge clock) begin
      rsp_payload_type exp_rsp;
      if (reset) begin
         trie_root = 0;
         node_count = 0;
         route_count = 0;
         limit_reg = 9'd256;
         hits_on = 1'b0;
         fail_count = 0;
         expected_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result transaction, status %0d", rsp_data.status);
               fail_count++;
            end else begin
               exp_rsp = expected_rsp.pop_front();
               if (rsp_data.status !== exp_rsp.status) begin
                  $error("status: expected %0d, actual %0d", exp_rsp.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.data_out !== exp_rsp.data_out) begin
                  $error("data_out: expected %h, actual %h", exp_rsp.data_out,
                         rsp_data.data_out);
                  fail_count++;
               end
               if (rsp_data.hits_out !== exp_rsp.hits_out) begin
                  $error("hits_out: expected %h, actual %h", exp_rsp.hits_out,
                         rsp_data.hits_out);
                  fail_count++;
               end
               if (rsp_data.match_len !== exp_rsp.match_len) begin
                  $error("match_len: expected %0d, actual %0d", exp_rsp.match_len,
                         rsp_data.match_len);
                  fail_count++;
               end
            end
         end
         if (start && !busy) begin
            predict_response(req_data, exp_rsp);
            expected_rsp.push_back(exp_rsp);
         end
         if (csr_we) begin
            if (csr_index == CSR_ROUTE_LIMIT) limit_reg = csr_wdata;
            else hits_on = csr_wdata[0];
         end
      end
   end
endmodule

### sim/binary_trie_lpm_table_test.sv
`timescale 1ns / 1ps
// Testbench top for binary_trie_lpm_table: drives requests and register writes,
// gives the verdict. Depends on btlpm_pkg and binary_trie_lpm_table_checker.
module binary_trie_lpm_table_test;
   import btlpm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_payload_type req_data = '0;
   logic rsp_valid;
   rsp_payload_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = CSR_ROUTE_LIMIT;
   logic [LIMIT_W-1:0] csr_wdata = '0;
   int fail_count, pending, quiet_cycles, item_count;

   logic [31:0] prefix_base [8];
   logic [31:0] live_key[$];
   logic [5:0] live_len[$];

   binary_trie_lpm_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   binary_trie_lpm_table_checker route_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata), .fail_count(fail_count),
      .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= 5000) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   task automatic issue(input logic [2:0] op, input logic [31:0] key, input logic [5:0] len,
                        input logic [63:0] data, input logic clr);
      int unsigned pick, gap;
      start <= 1'b1;
      req_data <= '{req_type: op, prefix_bits: key, prefix_len: len, data_in: data,
                    clear_hits: clr};
      do @(posedge clock); while (busy);
      item_count++;
      pick = $urandom_range(0, 9);
      if (item_count % 200 < 40 || pick < 5) gap = 0;
      else if (pick < 9) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 60);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic idx, input logic [LIMIT_W-1:0] value);
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_request();
      int unsigned op_pick, sel;
      logic [31:0] key;
      logic [5:0] len;
      logic [2:0] op;
      op_pick = $urandom_range(0, 99);
      key = prefix_base[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(0, 31));
      len = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(33, 63))
                                         : 6'($urandom_range(0, 32));
      if (op_pick < 32) op = OP_INSERT;
      else if (op_pick < 47) op = OP_DELETE;
      else if (op_pick < 57) op = OP_SET;
      else if (op_pick < 70) op = OP_GET;
      else if (op_pick < 95) op = OP_LOOKUP;
      else op = 3'($urandom_range(5, 7));
      if (op != OP_INSERT && live_key.size() > 0 && $urandom_range(0, 4) != 0) begin
         sel = $urandom_range(0, live_key.size() - 1);
         key = live_key[sel];
         len = live_len[sel];
         if (op == OP_LOOKUP) key = key ^ ($urandom >> $urandom_range(0, 31));
         if (op == OP_DELETE) begin
            live_key.delete(sel);
            live_len.delete(sel);
         end
      end
      if (op == OP_INSERT) begin
         live_key.push_back(key);
         live_len.push_back(len);
      end
      issue(op, key, len, rand64(), 1'($urandom));
   endtask

   task automatic random_phase(input logic [LIMIT_W-1:0] limit, input logic hits,
                               input int count);
      write_reg(CSR_ROUTE_LIMIT, limit);
      write_reg(CSR_HIT_ENABLE, hits);
      repeat (count) random_request();
   endtask

   initial begin
      foreach (prefix_base[i]) prefix_base[i] = $urandom;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(OP_LOOKUP, 32'h0, 6'd0, '0, 1'b0);
      issue(OP_INSERT, 32'h0, 6'd0, '1, 1'b0);
      issue(OP_INSERT, 32'hFFFF_FFFF, 6'd32, 64'h0, 1'b0);
      issue(OP_INSERT, 32'hFFFF_FFFF, 6'd63, '1, 1'b0);
      issue(OP_INSERT, 32'h8000_0000, 6'd1, 64'hA5A5_5A5A_0F0F_F0F0, 1'b0);
      issue(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, '0, 1'b0);
      issue(OP_LOOKUP, 32'h0000_0001, 6'd63, '0, 1'b0);
      issue(OP_GET, 32'hFFFF_FFFF, 6'd32, '0, 1'b1);
      write_reg(CSR_HIT_ENABLE, 1'b1);
      issue(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, '0, 1'b0);
      issue(OP_LOOKUP, 32'h8000_0000, 6'd0, '0, 1'b0);
      issue(OP_GET, 32'hFFFF_FFFF, 6'd32, '0, 1'b1);
      issue(OP_GET, 32'hFFFF_FFFF, 6'd40, '0, 1'b0);
      issue(OP_SET, 32'h0, 6'd0, 64'h1234_5678_9ABC_DEF0, 1'b0);
      issue(OP_GET, 32'h0, 6'd0, '0, 1'b0);
      issue(3'd5, 32'hFFFF_FFFF, 6'd32, '1, 1'b1);
      issue(3'd6, 32'h0, 6'd0, '0, 1'b0);
      issue(3'd7, 32'h8000_0000, 6'd1, '0, 1'b0);
      issue(OP_DELETE, 32'hFFFF_FFFF, 6'd32, '0, 1'b0);
      issue(OP_DELETE, 32'hFFFF_FFFF, 6'd32, '0, 1'b0);
      issue(OP_LOOKUP, 32'hFFFF_FFFF, 6'd0, '0, 1'b0);
      write_reg(CSR_ROUTE_LIMIT, 9'd2);
      issue(OP_INSERT, 32'h4000_0000, 6'd2, '0, 1'b0);
      issue(OP_DELETE, 32'h0, 6'd0, '0, 1'b0);
      issue(OP_DELETE, 32'h8000_0000, 6'd1, '0, 1'b0);

      random_phase(9'd256, 1'b1, 300);
      random_phase(9'd3, 1'b0, 150);
      random_phase(9'd511, 1'b1, 250);
      random_phase(9'd0, 1'b1, 100);
      random_phase(9'd1, 1'b1, 80);
      random_phase(9'd256, 1'b1, 270);

      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
